@@ rtl/core/mktd_pkg.sv @@
// Shared types, widths and tables for the Morse key timing decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mktd_pkg;

  localparam int unsigned DOT_W      = 11;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned D10_W      = 20;
  localparam int unsigned TH_W       = 18;
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned EVQ_DEPTH  = 4;

  localparam logic [DOT_W-1:0]  DOT_RESET  = 11'd100;
  localparam logic [CHAR_W-1:0] CHAR_BANG  = 7'h21;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
  localparam logic [CODE_W-1:0] CODE_EMPTY = 16'h0001;
  // register index is paddr[2]
  localparam logic              REG_DOT_TIME = 1'b0;

  typedef enum logic [2:0] {
    EV_DOT,
    EV_DASH,
    EV_COMMIT,
    EV_COMMIT_WORD,
    EV_BANG
  } ev_e;

  // thresholds in tenths of a tick, plus the 7-dot time-out in ticks
  typedef struct packed {
    logic [TH_W-1:0]   t12;
    logic [TH_W-1:0]   t25;
    logic [TH_W-1:0]   t60;
    logic [TH_W-1:0]   t65;
    logic [TICK_W-1:0] t7;
  } thr_t;

  typedef struct packed {
    logic              char_valid;
    logic [CHAR_W-1:0] char_code;
    logic              word_end;
  } res_t;

  function automatic thr_t thr_of(logic [DOT_W-1:0] dot);
    logic [DOT_W-1:0] de;
    thr_t             t;
    de    = (dot == '0) ? DOT_W'(1) : dot;
    t.t12 = TH_W'(de) * TH_W'(12);
    t.t25 = TH_W'(de) * TH_W'(25);
    t.t60 = TH_W'(de) * TH_W'(60);
    t.t65 = TH_W'(de) * TH_W'(65);
    t.t7  = TICK_W'(de) * TICK_W'(7);
    return t;
  endfunction

  // marker bit, then one bit per symbol: 0 dot, 1 dash
  function automatic logic [CHAR_W-1:0] letter_of(logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      16'h0005: ch = 7'h61;
      16'h0018: ch = 7'h62;
      16'h001A: ch = 7'h63;
      16'h000C: ch = 7'h64;
      16'h0002: ch = 7'h65;
      16'h0012: ch = 7'h66;
      16'h000E: ch = 7'h67;
      16'h0010: ch = 7'h68;
      16'h0004: ch = 7'h69;
      16'h0017: ch = 7'h6A;
      16'h000D: ch = 7'h6B;
      16'h0014: ch = 7'h6C;
      16'h0007: ch = 7'h6D;
      16'h0006: ch = 7'h6E;
      16'h000F: ch = 7'h6F;
      16'h0016: ch = 7'h70;
      16'h001D: ch = 7'h71;
      16'h000A: ch = 7'h72;
      16'h0008: ch = 7'h73;
      16'h0003: ch = 7'h74;
      16'h0009: ch = 7'h75;
      16'h0011: ch = 7'h76;
      16'h000B: ch = 7'h77;
      16'h0019: ch = 7'h78;
      16'h001B: ch = 7'h79;
      16'h001C: ch = 7'h7A;
      default:  ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/morse_key_timing_decoder.sv @@
// Morse key timing decoder: key samples in, decoded letters out.
// Usage:
//   Input queue: drive key_pressed_i with push high, one beat per timebase
//   tick; a beat is taken at an edge where push is high and full is low.
//   Result queue: while empty is low the oldest result sits on
//   char_valid_o / char_code_o / word_end_o; pop takes it.
//   APB port: register dot_time (11 bits) at address 0, writable and
//   readable, reset value 100; pready is always high.
// Timing: one input beat per clock sustained while full stays low. A
//   beat that yields a result goes through the event queue: the accepting
//   edge queues the classified event, and a later edge, once the result
//   buffer has room, decodes it into the result buffer. A four-entry event
//   queue sits between front and back and a two-beat buffer holds results.
// Stall: if pop stays low the result buffer fills, the back end stops
//   draining events, and full rises once four events are queued.
// Reset: rst_ni (async, active low) clears both queues, the timing state
//   to idle and the symbol code to empty, and sets dot_time to 100.
// Depends on mktd_pkg, mktd_front, mktd_evq and mktd_back.
`timescale 1ns / 1ps

module morse_key_timing_decoder #(
  parameter int unsigned EvqDepth = mktd_pkg::EVQ_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic                               key_pressed_i,
  output logic                               empty,
  input  logic                               pop,
  output logic                               char_valid_o,
  output logic [mktd_pkg::CHAR_W-1:0]        char_code_o,
  output logic                               word_end_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mktd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mktd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mktd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import mktd_pkg::*;

  logic [DOT_W-1:0] dot_q;
  thr_t             thr_q;
  logic             cfg_wr;
  logic             in_take;
  logic             ev_valid;
  ev_e              ev_in, ev_out;
  logic             evq_empty, ev_pop;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_DOT_TIME);
  assign prdata  = (paddr[2] == REG_DOT_TIME) ? APB_DATA_W'(dot_q) : '0;
  assign in_take = push && !full;

  // thresholds follow the written value at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= DOT_RESET;
      thr_q <= thr_of(DOT_RESET);
    end else if (cfg_wr) begin
      dot_q <= pwdata[DOT_W-1:0];
      thr_q <= thr_of(pwdata[DOT_W-1:0]);
    end
  end

  mktd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_take),
    .key_pressed_i (key_pressed_i),
    .thr_i         (thr_q),
    .ev_valid_o    (ev_valid),
    .ev_o          (ev_in)
  );

  mktd_evq #(
    .Depth (EvqDepth)
  ) u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_valid),
    .data_i  (ev_in),
    .full_o  (full),
    .pop_i   (ev_pop),
    .empty_o (evq_empty),
    .data_o  (ev_out)
  );

  mktd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_empty_i   (evq_empty),
    .ev_i         (ev_out),
    .ev_pop_o     (ev_pop),
    .empty        (empty),
    .pop          (pop),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .word_end_o   (word_end_o)
  );

endmodule

@@ rtl/core/mktd_front.sv @@
// Front end: times key levels and turns level changes and time-outs into symbol events.
// Depends on mktd_pkg.
`timescale 1ns / 1ps

module mktd_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic         key_pressed_i,
  input  mktd_pkg::thr_t thr_i,
  output logic         ev_valid_o,
  output mktd_pkg::ev_e  ev_o
);
  import mktd_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_WAIT = 2'd2;

  logic [1:0]        mode_q, mode_d;
  logic              last_q, last_d;
  logic [TICK_W-1:0] el_q, el_d;
  logic [TICK_W-1:0] el_inc;
  logic [D10_W-1:0]  d10;

  assign el_inc = (el_q == '1) ? el_q : el_q + TICK_W'(1);
  assign d10    = {el_inc, 4'b0000} - {2'b00, el_inc, 2'b00} - {3'b000, el_inc, 1'b0};

  always_comb begin
    mode_d     = mode_q;
    last_d     = last_q;
    el_d       = el_q;
    ev_valid_o = 1'b0;
    ev_o       = EV_DOT;
    case (mode_q)
      MODE_WAIT: begin
        if (!key_pressed_i) begin
          mode_d = MODE_RUN;
          last_d = 1'b0;
          el_d   = '0;
        end else begin
          el_d = el_inc;
        end
      end
      MODE_RUN: begin
        if (key_pressed_i != last_q) begin
          last_d = key_pressed_i;
          el_d   = '0;
          if (key_pressed_i) begin
            // gap ended: close the letter when long enough
            if (d10 > D10_W'(thr_i.t25)) begin
              ev_valid_o = 1'b1;
              ev_o = (d10 > D10_W'(thr_i.t65)) ? EV_COMMIT_WORD : EV_COMMIT;
            end
          end else if (d10 < D10_W'(thr_i.t12)) begin
            ev_valid_o = 1'b1;
            ev_o       = EV_DOT;
          end else if (d10 < D10_W'(thr_i.t60)) begin
            ev_valid_o = 1'b1;
            ev_o       = EV_DASH;
          end else begin
            ev_valid_o = 1'b1;
            ev_o       = EV_BANG;
            mode_d     = MODE_IDLE;
          end
        end else begin
          el_d = el_inc;
          if (el_inc >= thr_i.t7) begin
            ev_valid_o = 1'b1;
            if (key_pressed_i) begin
              ev_o   = EV_BANG;
              mode_d = MODE_WAIT;
            end else begin
              ev_o   = EV_COMMIT_WORD;
              mode_d = MODE_IDLE;
            end
          end
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (key_pressed_i) begin
          mode_d = MODE_RUN;
          last_d = 1'b1;
          el_d   = '0;
        end
      end
    endcase
    if (!valid_i) begin
      ev_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      last_q <= 1'b0;
      el_q   <= '0;
    end else if (valid_i) begin
      mode_q <= mode_d;
      last_q <= last_d;
      el_q   <= el_d;
    end
  end

endmodule

@@ rtl/core/mktd_evq.sv @@
// Small event queue between the timing front end and the symbol back end.
// Depends on mktd_pkg.
`timescale 1ns / 1ps

module mktd_evq #(
  parameter int unsigned Depth = mktd_pkg::EVQ_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mktd_pkg::ev_e data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mktd_pkg::ev_e data_o
);
  import mktd_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  ev_e             mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [AW-1:0] nxt(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= nxt(wr_q);
      end
      if (do_pop) begin
        rd_q <= nxt(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/core/mktd_back.sv @@
// Back end: builds the dot/dash code from events, decodes letters and
// queues results in a two-beat output buffer. Depends on mktd_pkg.
`timescale 1ns / 1ps

module mktd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ev_empty_i,
  input  mktd_pkg::ev_e ev_i,
  output logic          ev_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic          char_valid_o,
  output logic [mktd_pkg::CHAR_W-1:0] char_code_o,
  output logic          word_end_o
);
  import mktd_pkg::*;

  logic [CODE_W-1:0] sym_q, sym_d;
  logic              ovf_q, ovf_d;
  res_t              buf_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;
  logic              room, res_push, out_pop;
  res_t              res;
  logic [CHAR_W-1:0] ch;

  assign room     = (cnt_q != 2'd2);
  assign ev_pop_o = !ev_empty_i && room;
  assign ch       = ovf_q ? CHAR_NONE : letter_of(sym_q);
  assign out_pop  = pop && !empty;
  assign empty    = (cnt_q == 2'd0);

  always_comb begin
    sym_d    = sym_q;
    ovf_d    = ovf_q;
    res_push = 1'b0;
    res      = '{char_valid: 1'b0, char_code: CHAR_NONE, word_end: 1'b0};
    if (ev_pop_o) begin
      case (ev_i)
        EV_DOT, EV_DASH: begin
          // hold the code once 15 symbols are in
          if (sym_q[CODE_W-1]) begin
            ovf_d = 1'b1;
          end else begin
            sym_d = {sym_q[CODE_W-2:0], (ev_i == EV_DASH)};
          end
        end
        EV_COMMIT, EV_COMMIT_WORD: begin
          sym_d    = CODE_EMPTY;
          ovf_d    = 1'b0;
          res_push = (ch != CHAR_NONE) || (ev_i == EV_COMMIT_WORD);
          res      = '{char_valid: (ch != CHAR_NONE), char_code: ch,
                       word_end: (ev_i == EV_COMMIT_WORD)};
        end
        EV_BANG: begin
          sym_d    = CODE_EMPTY;
          ovf_d    = 1'b0;
          res_push = 1'b1;
          res      = '{char_valid: 1'b1, char_code: CHAR_BANG, word_end: 1'b0};
        end
        default: begin
          sym_d = sym_q;
        end
      endcase
    end
  end

  assign char_valid_o = buf_q[rd_q].char_valid;
  assign char_code_o  = buf_q[rd_q].char_code;
  assign word_end_o   = buf_q[rd_q].word_end;

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      buf_q[wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= CODE_EMPTY;
      ovf_q <= 1'b0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      sym_q <= sym_d;
      ovf_q <= ovf_d;
      if (res_push) begin
        wr_q <= !wr_q;
      end
      if (out_pop) begin
        rd_q <= !rd_q;
      end
      if (res_push && !out_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (out_pop && !res_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

@@ sim/mktd_decode_checker.sv @@
// Checker for the Morse key timing decoder: predicts decoded characters from
// accepted key beats and dot_time writes, and compares popped results.
// Depends on mktd_pkg for widths, the result struct and register index.
`timescale 1ns / 1ps

module mktd_decode_checker
  import mktd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  logic                  key_pressed_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  logic                  char_valid_i,
  input  logic [CHAR_W-1:0]     char_code_i,
  input  logic                  word_end_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic [APB_DATA_W-1:0] prdata_i,
  input  logic                  pready_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam logic [CHAR_W-1:0] LETTER_A = 7'h61;

  typedef enum logic [1:0] {
    KEY_IDLE,
    KEY_RUN,
    KEY_HOLD
  } key_mode_e;

  logic [DOT_W-1:0]  dot_q   = DOT_RESET;
  logic              level_q = 1'b0;
  logic [TICK_W-1:0] ticks_q = '0;
  logic [CODE_W-1:0] code_q  = CODE_EMPTY;
  logic              spill_q = 1'b0;
  key_mode_e         mode_q  = KEY_IDLE;
  res_t              chars_due[$];
  res_t              due;
  int                errs    = 0;

  function automatic string pattern_of(int idx);
    case (idx)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      default: return "--..";
    endcase
  endfunction

  // rebuild each letter's marker-prefixed code from its pattern and match
  function automatic logic [CHAR_W-1:0] decode(logic [CODE_W-1:0] code);
    string             p;
    logic [CODE_W-1:0] c;
    logic [CHAR_W-1:0] ch;
    ch = CHAR_NONE;
    for (int i = 0; i < 26; i++) begin
      p = pattern_of(i);
      c = CODE_EMPTY;
      for (int j = 0; j < p.len(); j++) c = {c[CODE_W-2:0], p[j] == "-"};
      if (c == code) ch = LETTER_A + CHAR_W'(i);
    end
    return ch;
  endfunction

  task automatic close_letter(input logic word);
    logic [CHAR_W-1:0] ch;
    res_t              r;
    ch = spill_q ? CHAR_NONE : decode(code_q);
    code_q = CODE_EMPTY;
    spill_q = 1'b0;
    if (ch != CHAR_NONE || word) begin
      r.char_valid = (ch != CHAR_NONE);
      r.char_code  = ch;
      r.word_end   = word;
      chars_due = {chars_due, r};
    end
  endtask

  task automatic flag_bang();
    res_t r;
    code_q = CODE_EMPTY;
    spill_q = 1'b0;
    r.char_valid = 1'b1;
    r.char_code  = CHAR_BANG;
    r.word_end   = 1'b0;
    chars_due = {chars_due, r};
  endtask

  task automatic add_mark(input logic dash);
    // a full code keeps its bits and only flags the spill
    if (code_q[CODE_W-1]) spill_q = 1'b1;
    else code_q = {code_q[CODE_W-2:0], dash};
  endtask

  task automatic take_sample(input logic lvl);
    int unsigned e;
    int unsigned d10;
    e = (dot_q == '0) ? 1 : int'(dot_q);
    case (mode_q)
      KEY_HOLD: begin
        if (!lvl) begin
          mode_q  = KEY_RUN;
          level_q = 1'b0;
          ticks_q = '0;
        end else if (ticks_q != '1) begin
          ticks_q = ticks_q + 1'b1;
        end
      end
      KEY_RUN: begin
        if (ticks_q != '1) ticks_q = ticks_q + 1'b1;
        d10 = 10 * ticks_q;
        if (lvl != level_q) begin
          level_q = lvl;
          ticks_q = '0;
          if (lvl) begin
            if (d10 > 25 * e) close_letter(d10 > 65 * e);
          end else if (d10 < 12 * e) begin
            add_mark(1'b0);
          end else if (d10 < 60 * e) begin
            add_mark(1'b1);
          end else begin
            mode_q = KEY_IDLE;
            flag_bang();
          end
        end else if (ticks_q >= 7 * e) begin
          if (lvl) begin
            mode_q = KEY_HOLD;
            flag_bang();
          end else begin
            mode_q = KEY_IDLE;
            close_letter(1'b1);
          end
        end
      end
      default: begin
        // the gap before the first press is not timed
        mode_q = KEY_IDLE;
        if (lvl) begin
          mode_q  = KEY_RUN;
          level_q = 1'b1;
          ticks_q = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q   = DOT_RESET;
      level_q = 1'b0;
      ticks_q = '0;
      code_q  = CODE_EMPTY;
      spill_q = 1'b0;
      mode_q  = KEY_IDLE;
      chars_due.delete();
      pending_o <= 0;
      errors_o  <= errs;
    end else begin
      if (pop_i && !empty_i) begin
        if (chars_due.size() == 0) begin
          errs++;
          $display("%0t: unexpected result beat: valid=%0b code=%02h word_end=%0b",
                   $time, char_valid_i, char_code_i, word_end_i);
        end else begin
          due = chars_due.pop_front();
          if (due.char_valid !== char_valid_i || due.char_code !== char_code_i ||
              due.word_end !== word_end_i) begin
            errs++;
            $display("%0t: result mismatch: expected valid=%0b code=%02h word_end=%0b,",
                     $time, due.char_valid, due.char_code, due.word_end,
                     " actual valid=%0b code=%02h word_end=%0b",
                     char_valid_i, char_code_i, word_end_i);
          end
        end
      end
      if (push_i && !full_i) take_sample(key_pressed_i);
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == REG_DOT_TIME) dot_q = pwdata_i[DOT_W-1:0];
        end else if (prdata_i !== APB_DATA_W'(dot_q)) begin
          errs++;
          $display("%0t: dot_time readback mismatch: expected %0d, actual %0d",
                   $time, dot_q, prdata_i);
        end
      end
      pending_o <= chars_due.size();
      errors_o  <= errs;
    end
  end

endmodule

@@ sim/tb_morse_key_timing_decoder.sv @@
// Testbench top for the Morse key timing decoder: drives key beats, dot_time
// writes and result pops; mktd_decode_checker predicts and compares.
// Depends on mktd_pkg, morse_key_timing_decoder and mktd_decode_checker.
`timescale 1ns / 1ps

module tb_morse_key_timing_decoder;
  import mktd_pkg::*;

  localparam int unsigned RUN_LIMIT    = 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_OFF     = 400;
  localparam int unsigned PHASE_KEYS   = 60;

  typedef enum {
    SPAN_DOT,
    SPAN_DASH,
    SPAN_MARK_GAP,
    SPAN_LETTER_GAP,
    SPAN_WORD_GAP,
    SPAN_LONG_PRESS
  } span_e;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  push       = 1'b0;
  logic                  full;
  logic                  key_level  = 1'b0;
  logic                  empty;
  logic                  pop        = 1'b0;
  logic                  char_valid;
  logic [CHAR_W-1:0]     char_code;
  logic                  word_end;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [APB_ADDR_W-1:0] paddr      = '0;
  logic [APB_DATA_W-1:0] pwdata     = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int          chk_errors;
  int          chk_pending;
  int          tx_idle_pct = 9;
  int          rx_idle_pct = 48;
  logic        hold_req    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned dot_eff     = 100;
  int unsigned keys_sent   = 0;
  int unsigned cycle_cnt   = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  morse_key_timing_decoder dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .key_pressed_i(key_level),
    .empty        (empty),
    .pop          (pop),
    .char_valid_o (char_valid),
    .char_code_o  (char_code),
    .word_end_o   (word_end),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mktd_decode_checker u_decode_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .key_pressed_i(key_level),
    .empty_i      (empty),
    .pop_i        (pop),
    .char_valid_i (char_valid),
    .char_code_i  (char_code),
    .word_end_i   (word_end),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .errors_o     (chk_errors),
    .pending_o    (chk_pending)
  );

  // result side: random pops, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_OFF;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    pop <= !hold_req && hold_left == 0 && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    return (hi < lo) ? lo : $urandom_range(hi, lo);
  endfunction

  // tick counts that land each level inside the wanted band of dot lengths
  function automatic int unsigned span_ticks(span_e kind);
    int unsigned e;
    e = dot_eff;
    case (kind)
      SPAN_DOT:        return pick(1, (12 * e - 1) / 10);
      SPAN_DASH:       return pick((12 * e + 9) / 10, (60 * e - 1) / 10);
      SPAN_MARK_GAP:   return pick(1, 25 * e / 10);
      SPAN_LETTER_GAP: return pick(25 * e / 10 + 1, 65 * e / 10);
      SPAN_WORD_GAP:   return pick(65 * e / 10 + 1, 7 * e);
      default:         return pick(6 * e, 7 * e);
    endcase
  endfunction

  task automatic send_level(input logic lvl);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    key_level <= lvl;
    @(posedge clk);
    while (full) @(posedge clk);
    keys_sent++;
  endtask

  task automatic drive_ticks(input logic lvl, input int unsigned n);
    repeat (n) send_level(lvl);
  endtask

  task automatic send_letter(input int unsigned nsym);
    for (int unsigned i = 0; i < nsym; i++) begin
      drive_ticks(1'b1, span_ticks($urandom_range(1) ? SPAN_DASH : SPAN_DOT));
      if (i + 1 < nsym) drive_ticks(1'b0, span_ticks(SPAN_MARK_GAP));
    end
  endtask

  // drop push and wait until every expected result is out and the pipe is quiet
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_beat(input logic wr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({REG_DOT_TIME, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dot(input int unsigned value);
    settle();
    apb_beat(1'b1, APB_DATA_W'(value));
    apb_beat(1'b0, '0);
    dot_eff = (value == 0) ? 1 : value;
  endtask

  task automatic random_unit();
    int unsigned r;
    int unsigned e;
    r = $urandom_range(99);
    e = dot_eff;
    if (r < 70) begin
      send_letter(($urandom_range(9) == 0) ? 5 : $urandom_range(4, 1));
      drive_ticks(1'b0, span_ticks(($urandom_range(3) == 0) ? SPAN_WORD_GAP
                                                            : SPAN_LETTER_GAP));
    end else if (r < 80) begin
      repeat ($urandom_range(4 * e, 1)) send_level(1'($urandom_range(1)));
    end else if (r < 86) begin
      drive_ticks(1'b1, span_ticks(SPAN_LONG_PRESS));
      drive_ticks(1'b0, span_ticks(SPAN_LETTER_GAP));
    end else if (r < 91) begin
      drive_ticks(1'b1, 7 * e + 1 + $urandom_range(3 * e));
      drive_ticks(1'b0, span_ticks(SPAN_LETTER_GAP));
    end else if (r < 96) begin
      send_letter($urandom_range(4, 1));
      drive_ticks(1'b0, 7 * e + 1 + $urandom_range(2 * e));
    end else begin
      send_letter($urandom_range(17, 15));
      drive_ticks(1'b0, span_ticks(($urandom_range(1) == 0) ? SPAN_WORD_GAP
                                                            : SPAN_LETTER_GAP));
    end
  endtask

  initial begin
    int unsigned start_keys;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apb_beat(1'b0, '0);

    // reset dot of 100: idle level is ignored, a short press starts a letter
    drive_ticks(1'b0, 3);
    drive_ticks(1'b1, 3);
    drive_ticks(1'b0, 2);

    // band edges, a word gap, both time-outs, release bang
    set_dot(5);
    drive_ticks(1'b1, 5);
    drive_ticks(1'b0, 12);
    drive_ticks(1'b1, 6);
    drive_ticks(1'b0, 13);
    drive_ticks(1'b1, 29);
    drive_ticks(1'b0, 32);
    drive_ticks(1'b1, 30);
    drive_ticks(1'b0, 4);
    drive_ticks(1'b1, 5);
    drive_ticks(1'b0, 33);
    drive_ticks(1'b1, 36);
    drive_ticks(1'b1, 4);
    drive_ticks(1'b0, 36);
    // fill the code to the top, then spill it, then an unknown pattern
    repeat (15) begin
      drive_ticks(1'b1, 1);
      drive_ticks(1'b0, 1);
    end
    drive_ticks(1'b0, 19);
    repeat (16) begin
      drive_ticks(1'b1, 1);
      drive_ticks(1'b0, 1);
    end
    drive_ticks(1'b0, 33);
    repeat (4) begin
      drive_ticks(1'b1, 10);
      drive_ticks(1'b0, 2);
    end
    drive_ticks(1'b0, 18);
    drive_ticks(1'b1, 1);
    drive_ticks(1'b0, 36);

    // zero dot time acts as one tick
    set_dot(0);
    repeat (3) begin
      drive_ticks(1'b1, 1);
      drive_ticks(1'b0, 1);
    end
    drive_ticks(1'b0, 2);
    drive_ticks(1'b1, 7);
    drive_ticks(1'b0, 2);
    drive_ticks(1'b1, 11);
    drive_ticks(1'b0, 8);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 9;
          rx_idle_pct <= 48;
          set_dot($urandom_range(3, 1));
        end
        1: begin
          tx_idle_pct = 48;
          rx_idle_pct <= 9;
          set_dot($urandom_range(4, 2));
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
          set_dot($urandom_range(4, 1));
        end
      endcase
      start_keys = keys_sent;
      do random_unit();
      while (keys_sent - start_keys < PHASE_KEYS);
    end

    // back up the result side until the block stalls its input
    set_dot(1);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (12) random_unit();

    settle();
    if (chk_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mktd_pkg.sv
rtl/core/mktd_front.sv
rtl/core/mktd_evq.sv
rtl/core/mktd_back.sv
rtl/core/morse_key_timing_decoder.sv
sim/mktd_decode_checker.sv
sim/tb_morse_key_timing_decoder.sv
